// ----- design/tcce_pkg.sv -----
// Shared types, constants and helpers for the text console cursor engine.
package tcce_pkg;

  localparam int MAX_TAB_STOP = 16;
  localparam int TAB_W        = $clog2(MAX_TAB_STOP + 1);
  localparam int MAX_RESULTS  = 32;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam logic [RES_CNT_W-1:0] TAB_SLOT_LIMIT = RES_CNT_W'(MAX_RESULTS - 2);

  localparam int CUR_W = 12;
  localparam int POS_W = 11;
  localparam logic [CUR_W-1:0] CUR_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_W      = CUR_W;
  localparam int DIVISOR_W  = 8;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_COLUMNS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TAB_STOP      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_NO_SCROLL     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_RANGE   = 3'd7;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_BS,
    KIND_CR,
    KIND_LF,
    KIND_TAB,
    KIND_DRAW
  } kind_t;

  typedef struct packed {
    logic [7:0] code;
    kind_t      kind;
    logic       printable;
  } item_t;

  typedef struct packed {
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [7:0]  line_columns;
    logic [4:0]  tab_stop;
    logic        no_scroll;
    logic [15:0] glyph_range;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    screen_width:  11'd320,
    screen_height: 11'd240,
    glyph_width:   8'd8,
    glyph_height:  8'd12,
    line_columns:  8'd40,
    tab_stop:      5'd8,
    no_scroll:     1'b0,
    glyph_range:   16'd24352
  };

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_ACT,
    ST_TAB_CHK,
    ST_TAB_WRAP,
    ST_TAB_DRAW,
    ST_TAB_DIV,
    ST_TAB_MOD,
    ST_DONE
  } state_t;

  function automatic logic is_printable(input logic [7:0] c, input logic [15:0] rng);
    logic [8:0] lim;
    lim = {1'b0, rng[7:0]} + {1'b0, rng[15:8]};
    return (c >= rng[7:0]) && ({1'b0, c} < lim);
  endfunction

endpackage

// ----- design/text_console_cursor_engine.sv -----
// Top level: configuration registers, front end, queue and back end.
// Path: a request passes the queue, the back-end item register and a pending register.
// The back-end sequencer finishes one character before it takes the next from the queue.
// Tab: each space runs the bit-serial divider twice unless the glyph width is zero.
// Line wraps are handled in a wrap state every character passes; results wait on stall.
// Reset: cursor homes, registers take defaults, queue empties; no clearing pass.
module text_console_cursor_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             char_valid,
  output logic                             char_stall,
  input  logic [7:0]                       char_code,
  output logic                             cmd_valid,
  input  logic                             cmd_stall,
  output logic [1:0]                       command,
  output logic [7:0]                       glyph_code,
  output logic [tcce_pkg::POS_W-1:0]       pos_x,
  output logic [tcce_pkg::POS_W-1:0]       pos_y,
  output logic                             last,
  input  logic                             cfg_we,
  input  logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcce_pkg::*;

  cfg_t    cfg;
  item_t   push_item;
  item_t   q_item;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[10:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[10:0];
        REG_GLYPH_WIDTH:   cfg.glyph_width   <= cfg_data[7:0];
        REG_GLYPH_HEIGHT:  cfg.glyph_height  <= cfg_data[7:0];
        REG_LINE_COLUMNS:  cfg.line_columns  <= cfg_data[7:0];
        REG_TAB_STOP:      cfg.tab_stop      <= cfg_data[4:0];
        REG_NO_SCROLL:     cfg.no_scroll     <= cfg_data[0];
        REG_GLYPH_RANGE:   cfg.glyph_range   <= cfg_data[15:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  tcce_front u_front (
    .char_valid (char_valid),
    .char_code  (char_code),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .char_stall (char_stall),
    .push       (q_push),
    .item       (push_item)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  tcce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_item     (q_item),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .glyph_code (glyph_code),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .last       (last)
  );

  a_ctl_fields_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (command != CMD_DRAW) |->
      (glyph_code == '0) && (pos_x == '0) && (pos_y == '0))
    else $error("scroll or clear request carries nonzero fields");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_stat.count != '0))
    else $error("back end popped an empty queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !cmd_valid)
    else $error("result valid right after reset");

endmodule

// ----- design/tcce_front.sv -----
// Front end: accepts character requests and classifies them for the queue.
module tcce_front (
  input  logic             char_valid,
  input  logic [7:0]       char_code,
  input  tcce_pkg::cfg_t   cfg,
  input  tcce_pkg::q_stat_t q_stat,
  output logic             char_stall,
  output logic             push,
  output tcce_pkg::item_t  item
);
  import tcce_pkg::*;

  assign char_stall = q_stat.full;
  assign push       = char_valid && !q_stat.full;

  always_comb begin
    item.code      = char_code;
    item.printable = is_printable(char_code, cfg.glyph_range);
    unique case (char_code)
      CHAR_BS:  item.kind = KIND_BS;
      CHAR_CR:  item.kind = KIND_CR;
      CHAR_LF:  item.kind = KIND_LF;
      CHAR_TAB: item.kind = KIND_TAB;
      default:  item.kind = KIND_DRAW;
    endcase
  end

endmodule

// ----- design/tcce_queue.sv -----
// Short queue of classified characters between front and back end.
module tcce_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcce_pkg::item_t   push_item,
  input  logic              pop,
  output tcce_pkg::item_t   pop_item,
  output tcce_pkg::q_stat_t stat
);
  import tcce_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign pop_item   = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

// ----- design/tcce_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module tcce_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tcce_pkg::DIV_W-1:0]     dividend,
  input  logic [tcce_pkg::DIVISOR_W-1:0] divisor,
  output logic                           busy,
  output logic [tcce_pkg::DIV_W-1:0]     quotient,
  output logic [tcce_pkg::DIVISOR_W-1:0] remainder
);
  import tcce_pkg::*;

  logic [DIV_CNT_W-1:0] steps;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign shifted = {remainder, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      steps <= steps - DIV_CNT_W'(1);
      if (steps == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIV_W-2:0], fits};
      remainder <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

endmodule

// ----- design/tcce_back.sv -----
// Back end: cursor sequencer, tab divider and result output register.
module tcce_back (
  input  logic                       clk,
  input  logic                       rst,
  input  tcce_pkg::cfg_t             cfg,
  input  tcce_pkg::item_t            q_item,
  input  tcce_pkg::q_stat_t          q_stat,
  output logic                       pop,
  output logic                       cmd_valid,
  input  logic                       cmd_stall,
  output logic [1:0]                 command,
  output logic [7:0]                 glyph_code,
  output logic [tcce_pkg::POS_W-1:0] pos_x,
  output logic [tcce_pkg::POS_W-1:0] pos_y,
  output logic                       last
);
  import tcce_pkg::*;

  state_t               state;
  state_t               state_next;
  item_t                item;
  logic [CUR_W-1:0]     col;
  logic [CUR_W-1:0]     row;
  logic [CUR_W-1:0]     col_next;
  logic [CUR_W-1:0]     row_next;
  logic [RES_CNT_W-1:0] res_cnt;

  logic                 pend_valid;
  cmd_t                 pend_cmd;
  logic [7:0]           pend_code;
  logic [POS_W-1:0]     pend_x;
  logic [POS_W-1:0]     pend_y;

  cmd_t                 out_cmd;

  logic                 emit_req;
  cmd_t                 emit_cmd;
  logic [7:0]           emit_code;
  logic [POS_W-1:0]     emit_x;
  logic [POS_W-1:0]     emit_y;

  logic                 out_free;
  logic                 adv;
  logic                 move;
  logic                 is_done;

  logic [CUR_W:0]       col_gw;
  logic [CUR_W-1:0]     adv_col;
  logic                 wrap_over;
  logic                 wrap_flag;
  logic [CUR_W:0]       lf_sum;
  logic                 lf_over;
  logic [CUR_W-1:0]     row_add;
  cmd_t                 lf_cmd;
  logic [CUR_W-1:0]     lf_row;
  logic [15:0]          bs_prod;
  logic [CUR_W-1:0]     bs_col;
  logic [CUR_W-1:0]     row_up;
  logic [TAB_W-1:0]     tab_eff;
  logic                 sp_print;
  logic [POS_W-1:0]     draw_x;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_busy;
  logic [DIV_W-1:0]     div_quo;
  logic [DIVISOR_W-1:0] div_rem;

  tcce_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign col_gw    = {1'b0, col} + (CUR_W + 1)'(cfg.glyph_width);
  assign adv_col   = col_gw[CUR_W] ? CUR_MAX : col_gw[CUR_W-1:0];
  assign wrap_over = col_gw > (CUR_W + 1)'(cfg.screen_width);
  assign lf_sum    = {1'b0, row} + (CUR_W + 1)'({cfg.glyph_height, 1'b0});
  assign lf_over   = lf_sum > (CUR_W + 1)'(cfg.screen_height);
  assign row_add   = row + CUR_W'(cfg.glyph_height);
  assign lf_cmd    = cfg.no_scroll ? CMD_CLEAR : CMD_SCROLL;
  assign lf_row    = lf_over ? (cfg.no_scroll ? '0 : row) : row_add;
  assign bs_prod   = {8'd0, cfg.line_columns - 8'd1} * {8'd0, cfg.glyph_width};
  assign bs_col    = (cfg.line_columns == '0) ? '0 :
                     (bs_prod > 16'(CUR_MAX)) ? CUR_MAX : bs_prod[CUR_W-1:0];
  assign row_up    = (row >= CUR_W'(cfg.glyph_height)) ? row - CUR_W'(cfg.glyph_height) : '0;
  assign sp_print  = is_printable(CHAR_SPACE, cfg.glyph_range);
  assign wrap_flag = (state == ST_WRAP) ? item.printable : sp_print;
  assign draw_x    = (col > CUR_W'(POS_MAX)) ? POS_MAX : col[POS_W-1:0];

  always_comb begin
    if (cfg.tab_stop == '0) begin
      tab_eff = TAB_W'(1);
    end else if (int'(cfg.tab_stop) > MAX_TAB_STOP) begin
      tab_eff = TAB_W'(MAX_TAB_STOP);
    end else begin
      tab_eff = TAB_W'(cfg.tab_stop);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_stat.empty) state_next = ST_WRAP;
      end
      ST_WRAP: begin
        state_next = (item.kind == KIND_TAB) ? ST_TAB_CHK : ST_ACT;
      end
      ST_ACT: begin
        state_next = ST_DONE;
      end
      ST_TAB_CHK: begin
        state_next = (res_cnt > TAB_SLOT_LIMIT) ? ST_DONE : ST_TAB_WRAP;
      end
      ST_TAB_WRAP: begin
        state_next = ST_TAB_DRAW;
      end
      ST_TAB_DRAW: begin
        state_next = (cfg.glyph_width == '0) ? ST_DONE : ST_TAB_DIV;
      end
      ST_TAB_DIV: begin
        if (!div_busy) state_next = ST_TAB_MOD;
      end
      ST_TAB_MOD: begin
        if (!div_busy) state_next = (div_rem == '0) ? ST_DONE : ST_TAB_CHK;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_cmd  = CMD_DRAW;
    emit_code = '0;
    emit_x    = '0;
    emit_y    = '0;
    col_next  = col;
    row_next  = row;
    unique case (state)
      ST_WRAP, ST_TAB_WRAP: begin
        if (wrap_flag && wrap_over) begin
          col_next = '0;
          row_next = lf_row;
          emit_req = lf_over;
          emit_cmd = lf_cmd;
        end
      end
      ST_ACT: begin
        unique case (item.kind)
          KIND_BS: begin
            if (col >= CUR_W'(cfg.glyph_width)) begin
              col_next = col - CUR_W'(cfg.glyph_width);
            end else begin
              row_next = row_up;
              col_next = bs_col;
            end
          end
          KIND_CR: begin
            col_next = '0;
          end
          KIND_LF: begin
            row_next = lf_row;
            emit_req = lf_over;
            emit_cmd = lf_cmd;
            if (lf_over && cfg.no_scroll) col_next = '0;
          end
          KIND_DRAW: begin
            emit_req  = 1'b1;
            emit_code = item.code;
            emit_x    = draw_x;
            emit_y    = row[POS_W-1:0];
            col_next  = adv_col;
          end
          default: begin
            col_next = col;
          end
        endcase
      end
      ST_TAB_DRAW: begin
        emit_req  = 1'b1;
        emit_code = CHAR_SPACE;
        emit_x    = draw_x;
        emit_y    = row[POS_W-1:0];
        col_next  = adv_col;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign is_done   = (state == ST_DONE);
  assign out_free  = !cmd_valid || !cmd_stall;
  assign adv       = ((emit_req || is_done) && pend_valid) ? out_free : 1'b1;
  assign move      = adv && pend_valid && (emit_req || is_done);
  assign pop       = (state == ST_IDLE) && !q_stat.empty;

  assign div_start    = adv && (((state == ST_TAB_DRAW) && (cfg.glyph_width != '0)) ||
                                ((state == ST_TAB_DIV) && !div_busy));
  assign div_dividend = (state == ST_TAB_DRAW) ? col_next : div_quo;
  assign div_divisor  = (state == ST_TAB_DRAW) ? cfg.glyph_width : DIVISOR_W'(tab_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      col        <= '0;
      row        <= '0;
      res_cnt    <= '0;
      pend_valid <= 1'b0;
      cmd_valid  <= 1'b0;
    end else begin
      if (adv) begin
        state <= state_next;
        col   <= col_next;
        row   <= row_next;
      end
      if (adv && emit_req) begin
        res_cnt <= res_cnt + RES_CNT_W'(1);
      end else if (adv && is_done) begin
        res_cnt <= '0;
      end
      if (adv && emit_req) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        cmd_valid <= 1'b1;
      end else if (!cmd_stall) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= q_item;
    end
    if (adv && emit_req) begin
      pend_cmd  <= emit_cmd;
      pend_code <= emit_code;
      pend_x    <= emit_x;
      pend_y    <= emit_y;
    end
    if (move) begin
      out_cmd    <= pend_cmd;
      glyph_code <= pend_code;
      pos_x      <= pend_x;
      pos_y      <= pend_y;
      last       <= is_done;
    end
  end

  assign command = out_cmd;

endmodule

// ----- tb/text_console_cursor_engine_tb.sv -----
// Testbench for the text console cursor engine: directed and random characters.
`timescale 1ns / 100ps

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned COL_SAT = 4095;

  typedef struct {
    cmd_t        command;
    logic [7:0]  code;
    logic [10:0] x;
    logic [10:0] y;
    logic        last;
  } cmd_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_code = 8'd0;
  logic        cmd_valid;
  logic        cmd_stall = 1'b0;
  logic [1:0]  command;
  logic [7:0]  glyph_code;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  cfg_t        cfg = CFG_RESET;
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;
  cmd_rec_t    step_results[$];
  cmd_rec_t    pending_cmds[$];
  cmd_rec_t    head_cmd;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned configs_loaded = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;

  text_console_cursor_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .glyph_code (glyph_code),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands outstanding", cycles, pending_cmds.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Cursor predictor

  function automatic bit in_glyph_range(input logic [7:0] c);
    int unsigned first;
    int unsigned count;
    first = cfg.glyph_range[7:0];
    count = cfg.glyph_range[15:8];
    return (c >= first) && (c < first + count);
  endfunction

  function automatic void add_command(input cmd_t k, input logic [7:0] code,
                                      input int unsigned x, input int unsigned y);
    cmd_rec_t r;
    if (step_results.size() >= MAX_RESULTS) return;
    r.command = k;
    r.code    = code;
    r.x       = (x > 2047) ? 11'd2047 : x[10:0];
    r.y       = y[10:0];
    r.last    = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void advance_line();
    int unsigned gh;
    gh = cfg.glyph_height;
    if (cur_row + 2 * gh > cfg.screen_height) begin
      if (cfg.no_scroll) begin
        add_command(CMD_CLEAR, 8'd0, 0, 0);
        cur_col = 0;
        cur_row = 0;
      end else begin
        add_command(CMD_SCROLL, 8'd0, 0, 0);
      end
    end else begin
      cur_row += gh;
    end
  endfunction

  function automatic void wrap_if_needed(input logic [7:0] c);
    if (in_glyph_range(c) && cur_col + cfg.glyph_width > cfg.screen_width) begin
      cur_col = 0;
      advance_line();
    end
  endfunction

  function automatic void apply_code(input logic [7:0] c);
    int unsigned gw;
    int unsigned gh;
    int unsigned lc;
    int unsigned x;
    gw = cfg.glyph_width;
    gh = cfg.glyph_height;
    lc = cfg.line_columns;
    case (c)
      CHAR_BS: begin
        if (cur_col >= gw) begin
          cur_col -= gw;
        end else begin
          cur_row = (cur_row >= gh) ? cur_row - gh : 0;
          x = (lc == 0) ? 0 : (lc - 1) * gw;
          cur_col = (x > COL_SAT) ? COL_SAT : x;
        end
      end
      CHAR_CR: cur_col = 0;
      CHAR_LF: advance_line();
      default: begin
        add_command(CMD_DRAW, c, cur_col, cur_row);
        x = cur_col + gw;
        cur_col = (x > COL_SAT) ? COL_SAT : x;
      end
    endcase
  endfunction

  function automatic void predict_commands(input logic [7:0] c);
    int unsigned t;
    int unsigned col_units;
    step_results.delete();
    wrap_if_needed(c);
    if (c == CHAR_TAB) begin
      t = cfg.tab_stop;
      if (t == 0) t = 1;
      if (t > MAX_TAB_STOP) t = MAX_TAB_STOP;
      do begin
        if (step_results.size() > MAX_RESULTS - 2) break;
        wrap_if_needed(CHAR_SPACE);
        apply_code(CHAR_SPACE);
        col_units = (cfg.glyph_width == 0) ? 0 : cur_col / cfg.glyph_width;
      end while (col_units % t != 0);
    end else begin
      apply_code(c);
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) pending_cmds.push_back(step_results[i]);
  endfunction

  // Result checking

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 50)
      $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && cmd_valid && !cmd_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("command with nothing pending, command", command, -1);
      end else begin
        head_cmd = pending_cmds.pop_front();
        cmds_checked++;
        if (command !== head_cmd.command)
          report_mismatch("command", command, head_cmd.command);
        if (glyph_code !== head_cmd.code)
          report_mismatch("glyph_code", glyph_code, head_cmd.code);
        if (pos_x !== head_cmd.x) report_mismatch("pos_x", pos_x, head_cmd.x);
        if (pos_y !== head_cmd.y) report_mismatch("pos_y", pos_y, head_cmd.y);
        if (last !== head_cmd.last) report_mismatch("last", last, head_cmd.last);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_style)
      0: cmd_stall <= 1'b0;
      1: cmd_stall <= ($urandom_range(0, 1) == 1);
      2: cmd_stall <= ($urandom_range(0, 3) != 0);
      default: cmd_stall <= ~cmd_stall;
    endcase
  end

  // Request side

  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    char_valid <= 1'b1;
    char_code  <= c;
    do @(posedge clk); while (char_stall);
    chars_sent++;
    predict_commands(c);
  endtask

  task automatic drain_commands();
    @(negedge clk);
    char_valid <= 1'b0;
    burst_left = 0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_commands();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:  cfg.screen_width  = data[10:0];
      REG_SCREEN_HEIGHT: cfg.screen_height = data[10:0];
      REG_GLYPH_WIDTH:   cfg.glyph_width   = data[7:0];
      REG_GLYPH_HEIGHT:  cfg.glyph_height  = data[7:0];
      REG_LINE_COLUMNS:  cfg.line_columns  = data[7:0];
      REG_TAB_STOP:      cfg.tab_stop      = data[4:0];
      REG_NO_SCROLL:     cfg.no_scroll     = data[0];
      default:           cfg.glyph_range   = data;
    endcase
  endtask

  task automatic load_config(input cfg_t c);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH,  16'(c.screen_width));
    write_reg(REG_SCREEN_HEIGHT, 16'(c.screen_height));
    write_reg(REG_GLYPH_WIDTH,   16'(c.glyph_width));
    write_reg(REG_GLYPH_HEIGHT,  16'(c.glyph_height));
    write_reg(REG_LINE_COLUMNS,  16'(c.line_columns));
    write_reg(REG_TAB_STOP,      16'(c.tab_stop));
    write_reg(REG_NO_SCROLL,     16'(c.no_scroll));
    write_reg(REG_GLYPH_RANGE,   c.glyph_range);
    @(negedge clk);
    cfg_we <= 1'b0;
    configs_loaded++;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    c.screen_width  = (pick < 6) ? 11'($urandom_range(1, 120)) :
                      (pick < 8) ? 11'($urandom_range(1, 2047)) : 11'd2047;
    pick = $urandom_range(0, 9);
    c.screen_height = (pick < 7) ? 11'($urandom_range(1, 100)) :
                      (pick < 9) ? 11'($urandom_range(1, 2047)) : 11'd2047;
    pick = $urandom_range(0, 9);
    c.glyph_width   = (pick < 7) ? 8'($urandom_range(1, 16)) :
                      (pick < 9) ? 8'($urandom_range(1, 255)) : 8'd0;
    pick = $urandom_range(0, 9);
    c.glyph_height  = (pick < 8) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 255));
    pick = $urandom_range(0, 9);
    c.line_columns  = (pick < 7) ? 8'($urandom_range(1, 50)) :
                      (pick < 9) ? 8'($urandom_range(0, 255)) : 8'd255;
    c.tab_stop      = 5'($urandom_range(0, 31));
    c.no_scroll     = 1'($urandom_range(0, 1));
    c.glyph_range   = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) :
                      {8'($urandom_range(60, 255)), 8'($urandom_range(0, 40))};
    return c;
  endfunction

  function automatic logic [7:0] random_char();
    int unsigned pick;
    int unsigned first;
    int unsigned count;
    int unsigned v;
    pick  = $urandom_range(0, 99);
    first = cfg.glyph_range[7:0];
    count = cfg.glyph_range[15:8];
    if (pick < 45) begin
      v = (count == 0) ? $urandom_range(0, 255) : first + $urandom_range(0, count - 1);
      return (v > 255) ? 8'($urandom_range(0, 255)) : v[7:0];
    end
    if (pick < 55) return CHAR_LF;
    if (pick < 63) return CHAR_CR;
    if (pick < 71) return CHAR_BS;
    if (pick < 79) return CHAR_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  // Tests

  task automatic test_reset_defaults();
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_TAB);
    send_char(CHAR_BS);
    send_char(CHAR_CR);
    send_char(CHAR_LF);
    send_char(CHAR_BS);
    send_char(8'h7E);
    send_char(8'h78);
  endtask

  task automatic test_scroll_clear_and_result_cap();
    cfg_t c;
    c = '{screen_width: 11'd1, screen_height: 11'd1, glyph_width: 8'd1,
          glyph_height: 8'd1, line_columns: 8'd40, tab_stop: 5'd16,
          no_scroll: 1'b0, glyph_range: 16'hFF00};
    load_config(c);
    send_char(CHAR_TAB);
    send_char(CHAR_LF);
    c.no_scroll = 1'b1;
    load_config(c);
    send_char(CHAR_LF);
    send_char(8'h41);
    send_char(8'h42);
  endtask

  task automatic test_extremes();
    cfg_t c;
    c = '{screen_width: 11'd2047, screen_height: 11'd2047, glyph_width: 8'd255,
          glyph_height: 8'd255, line_columns: 8'd255, tab_stop: 5'd31,
          no_scroll: 1'b0, glyph_range: 16'hFFFF};
    load_config(c);
    send_char(CHAR_BS);
    send_char(8'h41);
    send_char(8'hFF);
    send_char(CHAR_TAB);
  endtask

  task automatic test_zero_settings();
    cfg_t c;
    c = CFG_RESET;
    c.line_columns = 8'd0;
    c.tab_stop     = 5'd0;
    c.glyph_range  = 16'h0000;
    load_config(c);
    send_char(CHAR_CR);
    send_char(CHAR_BS);
    c.glyph_width = 8'd0;
    load_config(c);
    send_char(CHAR_TAB);
    send_char(CHAR_LF);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      load_config(random_config());
      for (int i = 0; i < 30; i++) begin
        send_char(random_char());
        if ((phase == 0 && i == 17) || $urandom_range(0, 24) == 0) drain_commands();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_scroll_clear_and_result_cap();
    test_extremes();
    test_zero_settings();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d characters under %0d register settings plus reset defaults,",
             chars_sent, configs_loaded);
    $display("and compared %0d commands against the cursor predictor.", cmds_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
